// ===== rtl/fdtd_pkg.sv =====
// ----------------------------------------------------------------------------
// fdtd_pkg
// shared types, register codes and defaults of the split-field update stream
// ----------------------------------------------------------------------------
package fdtd_pkg;

  // default sizing
  localparam int MAX_ROW_DEF    = 1024;
  localparam int FIELD_BITS_DEF = 32;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // register widths
  localparam int LEN_W   = 11;
  localparam int ROW_W   = 16;

  // fraction bits of the fixed-point format
  localparam int FRAC_BITS = 16;

  // register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SWEEP_MODE  = 3'd0,
    REG_ROW_LENGTH  = 3'd1,
    REG_ROW_COUNT   = 3'd2,
    REG_OUTER_FIRST = 3'd3,
    REG_OUTER_STOP  = 3'd4,
    REG_INNER_FIRST = 3'd5,
    REG_INNER_STOP  = 3'd6
  } cfg_reg_t;

  // sweep codes
  localparam logic MODE_E = 1'b0;
  localparam logic MODE_H = 1'b1;

  // register reset values
  localparam logic             SWEEP_MODE_RST  = MODE_E;
  localparam logic [LEN_W-1:0] ROW_LENGTH_RST  = 11'd1024;
  localparam logic [ROW_W-1:0] ROW_COUNT_RST   = 16'd1;
  localparam logic [ROW_W-1:0] OUTER_FIRST_RST = 16'd1;
  localparam logic [ROW_W-1:0] OUTER_STOP_RST  = 16'd1;
  localparam logic [LEN_W-1:0] INNER_FIRST_RST = 11'd1;
  localparam logic [LEN_W-1:0] INNER_STOP_RST  = 11'd1;

  // per-cell control handed from the sequencer to the datapath
  typedef struct packed {
    logic mode;
    logic in_bounds;
    logic up_zero;
    logic left_zero;
    logic last;
  } cell_ctl_t;

endpackage

// ===== rtl/fdtd_ram.sv =====
// ----------------------------------------------------------------------------
// fdtd_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module fdtd_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/fdtd_ctrl.sv =====
// ----------------------------------------------------------------------------
// fdtd_ctrl
// configuration registers, raster counters, bounds test and line store clear
// ----------------------------------------------------------------------------
module fdtd_ctrl #(
  parameter int MAX_ROW = fdtd_pkg::MAX_ROW_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [fdtd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fdtd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_fire,
  output logic [$clog2(MAX_ROW)-1:0]         rd_addr,
  output fdtd_pkg::cell_ctl_t                cell_ctl,
  output logic                               clearing,
  output logic [$clog2(MAX_ROW)-1:0]         clr_addr
);

  localparam int AW = $clog2(MAX_ROW);
  localparam int CW = AW + 1;
  localparam int LW = (CW > fdtd_pkg::LEN_W) ? CW : fdtd_pkg::LEN_W;
  localparam int RW = fdtd_pkg::ROW_W;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_ROW);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ROW - 1);

  logic                        sweep_mode_r;
  logic [fdtd_pkg::LEN_W-1:0]  row_length_r;
  logic [RW-1:0]               row_count_r;
  logic [RW-1:0]               outer_first_r;
  logic [RW-1:0]               outer_stop_r;
  logic [fdtd_pkg::LEN_W-1:0]  inner_first_r;
  logic [fdtd_pkg::LEN_W-1:0]  inner_stop_r;

  logic [RW-1:0]               row_pos_r, row_pos_nxt;
  logic [AW-1:0]               col_pos_r, col_pos_nxt;
  logic                        clr_r;
  logic [AW-1:0]               clr_addr_r;

  logic [LW-1:0]               len_wide;
  logic [CW-1:0]               len;
  logic [RW-1:0]               cnt;
  logic [AW-1:0]               cp;
  logic [RW-1:0]               rp;
  logic [CW-1:0]               col_sel;
  logic [RW-1:0]               row_sel;
  logic [CW-1:0]               cp_inc;
  logic [RW:0]                 rp_inc;
  logic                        row_in, col_in;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_mode_r  <= fdtd_pkg::SWEEP_MODE_RST;
      row_length_r  <= fdtd_pkg::ROW_LENGTH_RST;
      row_count_r   <= fdtd_pkg::ROW_COUNT_RST;
      outer_first_r <= fdtd_pkg::OUTER_FIRST_RST;
      outer_stop_r  <= fdtd_pkg::OUTER_STOP_RST;
      inner_first_r <= fdtd_pkg::INNER_FIRST_RST;
      inner_stop_r  <= fdtd_pkg::INNER_STOP_RST;
    end else if (cfg_wr_en) begin
      unique case (fdtd_pkg::cfg_reg_t'(cfg_index))
        fdtd_pkg::REG_SWEEP_MODE:  sweep_mode_r  <= cfg_wdata[0];
        fdtd_pkg::REG_ROW_LENGTH:  row_length_r  <= cfg_wdata[fdtd_pkg::LEN_W-1:0];
        fdtd_pkg::REG_ROW_COUNT:   row_count_r   <= cfg_wdata[RW-1:0];
        fdtd_pkg::REG_OUTER_FIRST: outer_first_r <= cfg_wdata[RW-1:0];
        fdtd_pkg::REG_OUTER_STOP:  outer_stop_r  <= cfg_wdata[RW-1:0];
        fdtd_pkg::REG_INNER_FIRST: inner_first_r <= cfg_wdata[fdtd_pkg::LEN_W-1:0];
        fdtd_pkg::REG_INNER_STOP:  inner_stop_r  <= cfg_wdata[fdtd_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective extents and counters brought back inside them
  always_comb begin
    if (row_length_r == '0) begin
      len_wide = LW'(1);
    end else if (LW'(row_length_r) > MAX_LEN) begin
      len_wide = MAX_LEN;
    end else begin
      len_wide = LW'(row_length_r);
    end
    len = len_wide[CW-1:0];
    cnt = (row_count_r == '0) ? RW'(1) : row_count_r;
    cp  = (CW'(col_pos_r) >= len) ? '0 : col_pos_r;
    rp  = (row_pos_r >= cnt) ? '0 : row_pos_r;
  end

  // grid position of this cell, reversed in h mode
  always_comb begin
    if (sweep_mode_r == fdtd_pkg::MODE_H) begin
      col_sel = len - CW'(1) - CW'(cp);
      row_sel = cnt - RW'(1) - rp;
    end else begin
      col_sel = CW'(cp);
      row_sel = rp;
    end
    row_in = (row_sel >= outer_first_r) && (row_sel < outer_stop_r);
    col_in = (LW'(col_sel) >= LW'(inner_first_r)) && (LW'(col_sel) < LW'(inner_stop_r));
    rd_addr = col_sel[AW-1:0];
    cell_ctl.mode      = sweep_mode_r;
    cell_ctl.in_bounds = row_in && col_in;
    cell_ctl.up_zero   = (rp == '0);
    cell_ctl.left_zero = (cp == '0);
    cell_ctl.last      = (rp == cnt - RW'(1)) && (CW'(cp) == len - CW'(1));
  end

  // raster advance
  always_comb begin
    cp_inc      = CW'(cp) + CW'(1);
    rp_inc      = (RW+1)'(rp) + (RW+1)'(1);
    row_pos_nxt = row_pos_r;
    col_pos_nxt = col_pos_r;
    if (in_fire) begin
      if (cp_inc >= len) begin
        col_pos_nxt = '0;
        row_pos_nxt = (rp_inc >= (RW+1)'(cnt)) ? '0 : rp_inc[RW-1:0];
      end else begin
        col_pos_nxt = cp_inc[AW-1:0];
        row_pos_nxt = rp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r <= '0;
      col_pos_r <= '0;
    end else begin
      row_pos_r <= row_pos_nxt;
      col_pos_r <= col_pos_nxt;
    end
  end

  // line store clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == LAST_ADDR) begin
        clr_r <= 1'b0;
      end
    end
  end

  assign clearing = clr_r;
  assign clr_addr = clr_addr_r;

endmodule

// ===== rtl/fdtd_datapath.sv =====
// ----------------------------------------------------------------------------
// fdtd_datapath
// input register, neighbour selection and products, sum and saturation
// ----------------------------------------------------------------------------
module fdtd_datapath #(
  parameter int MAX_ROW    = fdtd_pkg::MAX_ROW_DEF,
  parameter int FIELD_BITS = fdtd_pkg::FIELD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_fire,
  output logic                               take,
  input  fdtd_pkg::cell_ctl_t                cell_ctl,
  input  logic [$clog2(MAX_ROW)-1:0]         rd_addr,
  input  logic signed [FIELD_BITS-1:0]       first_value,
  input  logic signed [FIELD_BITS-1:0]       second_value,
  input  logic signed [FIELD_BITS-1:0]       source_first,
  input  logic signed [FIELD_BITS-1:0]       source_second,
  input  logic signed [FIELD_BITS-1:0]       first_decay,
  input  logic signed [FIELD_BITS-1:0]       first_gain,
  input  logic signed [FIELD_BITS-1:0]       second_decay,
  input  logic signed [FIELD_BITS-1:0]       second_gain,
  input  logic [FIELD_BITS:0]                ram_q,
  output logic                               wr_en,
  output logic [$clog2(MAX_ROW)-1:0]         wr_addr,
  output logic [FIELD_BITS:0]                wr_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [FIELD_BITS-1:0]       new_first,
  output logic signed [FIELD_BITS-1:0]       new_second,
  output logic                               last_cell
);

  localparam int F   = FIELD_BITS;
  localparam int AW  = $clog2(MAX_ROW);
  localparam int SW  = F + 1;            // stored neighbour width
  localparam int DW  = F + 2;            // difference width
  localparam int PAW = 2 * F;            // decay product width
  localparam int PBW = 2 * F + 2;        // gain product width
  localparam int XW  = (PBW > 62) ? PBW : 62;
  localparam int TW  = 62;               // clamped term width
  localparam logic signed [XW-1:0] TLIM = {{(XW-61){1'b0}}, 1'b1, 60'b0};
  localparam logic signed [XW-1:0] NTLIM = -TLIM;
  localparam logic signed [TW:0]   FMAX = {{(TW+2-F){1'b0}}, {(F-1){1'b1}}};
  localparam logic signed [TW:0]   FMIN = ~FMAX;

  // floor(p / 2^16), clamped to +-2^60
  function automatic logic signed [TW-1:0] term_clamp(input logic signed [XW-1:0] p);
    logic signed [XW-1:0] s;
    s = p >>> fdtd_pkg::FRAC_BITS;
    if (s > TLIM) begin
      s = TLIM;
    end else if (s < NTLIM) begin
      s = NTLIM;
    end
    return s[TW-1:0];
  endfunction

  // saturate a sum to the field width
  function automatic logic signed [F-1:0] field_sat(input logic signed [TW:0] v);
    logic signed [TW:0] s;
    s = v;
    if (v > FMAX) begin
      s = FMAX;
    end else if (v < FMIN) begin
      s = FMIN;
    end
    return s[F-1:0];
  endfunction

  // stage 1: input register
  logic                  s1_v_r, s1_v_nxt;
  fdtd_pkg::cell_ctl_t   ctl_r;
  logic [AW-1:0]         addr_r;
  logic signed [F-1:0]   fv_r, sv_r, sf_r, ss_r, fa_r, fb_r, sa_r, sb_r;
  logic                  fwd_hit_r;
  logic signed [SW-1:0]  fwd_data_r;
  logic signed [SW-1:0]  prior_r;

  // stage 2: product register
  logic                  p_v_r, p_v_nxt;
  logic                  p_bounds_r, p_sub_r, p_last_r;
  logic signed [F-1:0]   p_fv_r, p_sv_r;
  logic signed [PAW-1:0] pa_r, pc_r;
  logic signed [PBW-1:0] pb_r, pd_r;

  // stage 3: result register
  logic                  o_v_r, o_v_nxt;
  logic signed [F-1:0]   o_first_r, o_second_r;
  logic                  o_last_r;

  logic                  o_en, p_en, s1_fire, o_load;
  logic signed [SW-1:0]  up, left, ez, keep_row, keep_prev;
  logic signed [DW-1:0]  d_first, d_second;
  logic signed [PAW-1:0] pa_nxt, pc_nxt;
  logic signed [PBW-1:0] pb_nxt, pd_nxt;
  logic signed [TW-1:0]  ta, tb, tc, td;
  logic signed [TW:0]    sum_first, sum_second;
  logic signed [F-1:0]   first_nxt, second_nxt;

  // pipeline flow
  always_comb begin
    o_en     = !o_v_r || out_ready;
    p_en     = !p_v_r || o_en;
    take     = !s1_v_r || p_en;
    s1_fire  = s1_v_r && p_en;
    o_load   = p_v_r && o_en;
    s1_v_nxt = in_fire ? 1'b1 : (s1_v_r && !p_en);
    p_v_nxt  = s1_fire ? 1'b1 : (p_v_r && !o_en);
    o_v_nxt  = o_load ? 1'b1 : (o_v_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      p_v_r  <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      p_v_r  <= p_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  // capture an item, and a line store write that lands on the address being read
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ctl_r      <= cell_ctl;
      addr_r     <= rd_addr;
      fv_r       <= first_value;
      sv_r       <= second_value;
      sf_r       <= source_first;
      ss_r       <= source_second;
      fa_r       <= first_decay;
      fb_r       <= first_gain;
      sa_r       <= second_decay;
      sb_r       <= second_gain;
      fwd_hit_r  <= s1_fire && (addr_r == rd_addr);
      fwd_data_r <= keep_row;
    end
  end

  // neighbours, curl differences and products
  always_comb begin
    if (ctl_r.up_zero) begin
      up = '0;
    end else if (fwd_hit_r) begin
      up = fwd_data_r;
    end else begin
      up = ram_q;
    end
    left = ctl_r.left_zero ? '0 : prior_r;
    ez   = SW'(sf_r) + SW'(ss_r);
    if (ctl_r.mode == fdtd_pkg::MODE_H) begin
      keep_row  = ez;
      keep_prev = ez;
      d_first   = DW'(left) - DW'(ez);
      d_second  = DW'(up) - DW'(ez);
    end else begin
      keep_row  = SW'(ss_r);
      keep_prev = SW'(sf_r);
      d_first   = DW'(ss_r) - DW'(up);
      d_second  = DW'(sf_r) - DW'(left);
    end
    pa_nxt = PAW'(fv_r) * PAW'(fa_r);
    pb_nxt = PBW'(fb_r) * PBW'(d_first);
    pc_nxt = PAW'(sv_r) * PAW'(sa_r);
    pd_nxt = PBW'(sb_r) * PBW'(d_second);
  end

  // line store write and previous cell, every cell
  assign wr_en   = s1_fire;
  assign wr_addr = addr_r;
  assign wr_data = keep_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_r <= '0;
    end else if (s1_fire) begin
      prior_r <= keep_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      p_bounds_r <= ctl_r.in_bounds;
      p_sub_r    <= (ctl_r.mode == fdtd_pkg::MODE_H);
      p_last_r   <= ctl_r.last;
      p_fv_r     <= fv_r;
      p_sv_r     <= sv_r;
      pa_r       <= pa_nxt;
      pb_r       <= pb_nxt;
      pc_r       <= pc_nxt;
      pd_r       <= pd_nxt;
    end
  end

  // truncate, add or subtract, and saturate
  always_comb begin
    ta = term_clamp(XW'(pa_r));
    tb = term_clamp(XW'(pb_r));
    tc = term_clamp(XW'(pc_r));
    td = term_clamp(XW'(pd_r));
    if (p_sub_r) begin
      sum_first  = (TW+1)'(ta) - (TW+1)'(tb);
      sum_second = (TW+1)'(tc) - (TW+1)'(td);
    end else begin
      sum_first  = (TW+1)'(ta) + (TW+1)'(tb);
      sum_second = (TW+1)'(tc) + (TW+1)'(td);
    end
    first_nxt  = p_bounds_r ? field_sat(sum_first) : p_fv_r;
    second_nxt = p_bounds_r ? field_sat(sum_second) : p_sv_r;
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_first_r  <= first_nxt;
      o_second_r <= second_nxt;
      o_last_r   <= p_last_r;
    end
  end

  assign out_valid  = o_v_r;
  assign new_first  = o_first_r;
  assign new_second = o_second_r;
  assign last_cell  = o_last_r;

endmodule

// ===== rtl/fdtd_field_update_stream_top.sv =====
// ----------------------------------------------------------------------------
// fdtd_field_update_stream_top
// split-field yee update of a streamed 2d grid, one cell per item
// ----------------------------------------------------------------------------
// The block takes one grid cell per clock and gives one updated cell per
// clock while the output is not stalled. The result passes the input
// register, the product register and the result register on its way to the
// outputs. A result waiting at the output does not stop the next items until
// the product and input registers are full too. The rate is set by the line
// store, one read and one write port, which carries the neighbour from the
// previous row, with a bypass for a write landing on the address being read.
// After reset the line store is cleared one entry a cycle, all MAX_ROW
// entries, and in_ready stays low meanwhile; configuration writes are taken
// as ever. Write registers only while no item is in flight.
module fdtd_field_update_stream_top #(
  parameter int MAX_ROW    = fdtd_pkg::MAX_ROW_DEF,
  parameter int FIELD_BITS = fdtd_pkg::FIELD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [fdtd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fdtd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [FIELD_BITS-1:0]      in_first_value,
  input  logic signed [FIELD_BITS-1:0]      in_second_value,
  input  logic signed [FIELD_BITS-1:0]      in_source_first,
  input  logic signed [FIELD_BITS-1:0]      in_source_second,
  input  logic signed [FIELD_BITS-1:0]      in_first_decay,
  input  logic signed [FIELD_BITS-1:0]      in_first_gain,
  input  logic signed [FIELD_BITS-1:0]      in_second_decay,
  input  logic signed [FIELD_BITS-1:0]      in_second_gain,
  // result items
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [FIELD_BITS-1:0]      out_new_first,
  output logic signed [FIELD_BITS-1:0]      out_new_second,
  output logic                              out_last_cell
);

  localparam int AW = $clog2(MAX_ROW);

  logic                 in_fire;
  logic                 take;
  logic                 clearing;
  logic [AW-1:0]        clr_addr;
  logic [AW-1:0]        rd_addr;
  fdtd_pkg::cell_ctl_t  cell_ctl;
  logic [FIELD_BITS:0]  ram_q;
  logic                 dp_wr_en;
  logic [AW-1:0]        dp_wr_addr;
  logic [FIELD_BITS:0]  dp_wr_data;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [FIELD_BITS:0]  ram_wdata;

  // input handshake
  assign in_ready = take && !clearing;
  assign in_fire  = in_valid && in_ready;

  fdtd_ctrl #(
    .MAX_ROW (MAX_ROW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .rd_addr   (rd_addr),
    .cell_ctl  (cell_ctl),
    .clearing  (clearing),
    .clr_addr  (clr_addr)
  );

  // line store write: clearing sweep or cell write-back
  assign ram_we    = clearing || dp_wr_en;
  assign ram_waddr = clearing ? clr_addr : dp_wr_addr;
  assign ram_wdata = clearing ? '0 : dp_wr_data;

  fdtd_ram #(
    .WIDTH (FIELD_BITS + 1),
    .DEPTH (MAX_ROW)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  fdtd_datapath #(
    .MAX_ROW    (MAX_ROW),
    .FIELD_BITS (FIELD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .take          (take),
    .cell_ctl      (cell_ctl),
    .rd_addr       (rd_addr),
    .first_value   (in_first_value),
    .second_value  (in_second_value),
    .source_first  (in_source_first),
    .source_second (in_source_second),
    .first_decay   (in_first_decay),
    .first_gain    (in_first_gain),
    .second_decay  (in_second_decay),
    .second_gain   (in_second_gain),
    .ram_q         (ram_q),
    .wr_en         (dp_wr_en),
    .wr_addr       (dp_wr_addr),
    .wr_data       (dp_wr_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .new_first     (out_new_first),
    .new_second    (out_new_second),
    .last_cell     (out_last_cell)
  );

  // no cell write-back can collide with the clearing sweep
  a_clear_no_writeback: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !dp_wr_en)
    else $error("cell write-back during line store clearing");

  // no item is taken while the line store is being cleared
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_fire)
    else $error("item accepted during line store clearing");

  // the clearing sweep never restarts once items flow
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !clearing)
    else $error("line store clearing restarted after an item");

endmodule

// ===== verif/fdtd_field_update_stream_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fdtd_field_update_stream_top_tb
// self-checking bench for the split-field yee update stream
// ----------------------------------------------------------------------------
// Streams grid cells through the block in both sweep directions under many
// array sizes and compute bounds, with random gaps on the input and random
// stalls on the output. A scoreboard predicts every updated cell from its own
// copy of the line store, previous-cell register and raster counters, and
// checks the results in order, field by field.
module fdtd_field_update_stream_top_tb;
  import fdtd_pkg::*;

  localparam int FW         = FIELD_BITS_DEF;
  localparam int ROW_CAP    = MAX_ROW_DEF;
  localparam int CYCLE_CAP  = 400000;
  localparam int RAND_ITEMS = 560;
  localparam int LONG_ROW   = 300;

  typedef logic signed [FW-1:0] field_t;

  typedef struct packed {
    field_t first_value;
    field_t second_value;
    field_t source_first;
    field_t source_second;
    field_t first_decay;
    field_t first_gain;
    field_t second_decay;
    field_t second_gain;
  } cell_t;

  typedef struct packed {
    field_t new_first;
    field_t new_second;
    logic   last_cell;
  } cell_result_t;

  // predicts updated cells and checks them in arrival order
  class field_update_scoreboard;
    logic        sweep;
    int unsigned row_length, row_count;
    int unsigned outer_first, outer_stop, inner_first, inner_stop;
    longint      line_buf[ROW_CAP];
    longint      prev_cell;
    int unsigned row_pos, col_pos;
    cell_result_t expected_q[$];
    int          fail_count;

    function new();
      sweep       = SWEEP_MODE_RST;
      row_length  = 32'(ROW_LENGTH_RST);
      row_count   = 32'(ROW_COUNT_RST);
      outer_first = 32'(OUTER_FIRST_RST);
      outer_stop  = 32'(OUTER_STOP_RST);
      inner_first = 32'(INNER_FIRST_RST);
      inner_stop  = 32'(INNER_STOP_RST);
      foreach (line_buf[i]) line_buf[i] = 0;
      prev_cell  = 0;
      row_pos    = 0;
      col_pos    = 0;
      fail_count = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SWEEP_MODE:  sweep       = val[0];
        REG_ROW_LENGTH:  row_length  = 32'(val[LEN_W-1:0]);
        REG_ROW_COUNT:   row_count   = 32'(val[ROW_W-1:0]);
        REG_OUTER_FIRST: outer_first = 32'(val[ROW_W-1:0]);
        REG_OUTER_STOP:  outer_stop  = 32'(val[ROW_W-1:0]);
        REG_INNER_FIRST: inner_first = 32'(val[LEN_W-1:0]);
        REG_INNER_STOP:  inner_stop  = 32'(val[LEN_W-1:0]);
        default: ;
      endcase
    endfunction

    // floor(a*b / 2^16), clamped to +-2^60
    function longint q16_product(longint a, longint b);
      logic signed [127:0] p;
      logic signed [127:0] q;
      longint cap;
      cap = 64'sd1 <<< 60;
      p = a * b;
      q = p >>> FRAC_BITS;
      if (q > cap) q = cap;
      else if (q < -cap) q = -cap;
      return longint'(q);
    endfunction

    function field_t saturate_field(longint v);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (FW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return field_t'(hi);
      if (v < lo) return field_t'(lo);
      return field_t'(v);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // one accepted cell: work out its result and advance the raster counters
    function void note_cell(cell_t c);
      longint fv, sv, sf, ss, fa, fb, sa, sb;
      longint up, left, ez, keep_prev, keep_row;
      int unsigned len, cnt, row, col;
      cell_result_t res;
      fv = longint'(c.first_value);
      sv = longint'(c.second_value);
      sf = longint'(c.source_first);
      ss = longint'(c.source_second);
      fa = longint'(c.first_decay);
      fb = longint'(c.first_gain);
      sa = longint'(c.second_decay);
      sb = longint'(c.second_gain);
      len = (row_length == 0) ? 1 : row_length;
      cnt = (row_count == 0) ? 1 : row_count;
      if (len > ROW_CAP) len = ROW_CAP;
      // counters left beyond a shrunk array restart
      if (row_pos >= cnt) row_pos = 0;
      if (col_pos >= len) col_pos = 0;
      if (sweep == MODE_E) begin
        row = row_pos;
        col = col_pos;
      end else begin
        row = cnt - 1 - row_pos;
        col = len - 1 - col_pos;
      end
      // neighbours missing on the first streamed row and cell read as zero
      up   = (row_pos == 0) ? 0 : line_buf[col];
      left = (col_pos == 0) ? 0 : prev_cell;
      ez   = sf + ss;
      if (sweep == MODE_E) begin
        keep_prev = sf;
        keep_row  = ss;
      end else begin
        keep_prev = ez;
        keep_row  = ez;
      end
      res.new_first  = c.first_value;
      res.new_second = c.second_value;
      if (row >= outer_first && row < outer_stop && col >= inner_first && col < inner_stop)
      begin
        if (sweep == MODE_E) begin
          res.new_first  = saturate_field(q16_product(fv, fa) + q16_product(fb, ss - up));
          res.new_second = saturate_field(q16_product(sv, sa) + q16_product(sb, sf - left));
        end else begin
          res.new_first  = saturate_field(q16_product(fv, fa) - q16_product(fb, left - ez));
          res.new_second = saturate_field(q16_product(sv, sa) - q16_product(sb, up - ez));
        end
      end
      line_buf[col] = keep_row;
      prev_cell     = keep_prev;
      res.last_cell = (row_pos == cnt - 1) && (col_pos == len - 1);
      if (col_pos + 1 >= len) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= cnt) ? 0 : row_pos + 1;
      end else begin
        col_pos++;
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(field_t nf, field_t ns, logic last);
      cell_result_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item, new_first %0d new_second %0d last_cell %0b",
                 $time, nf, ns, last);
        fail_count++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (nf !== exp_res.new_first) begin
        $display("%0t: new_first expected %0d got %0d", $time, exp_res.new_first, nf);
        fail_count++;
      end
      if (ns !== exp_res.new_second) begin
        $display("%0t: new_second expected %0d got %0d", $time, exp_res.new_second, ns);
        fail_count++;
      end
      if (last !== exp_res.last_cell) begin
        $display("%0t: last_cell expected %0b got %0b", $time, exp_res.last_cell, last);
        fail_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  cell_t in_cell = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  field_t out_new_first, out_new_second;
  logic out_last_cell;

  field_update_scoreboard sb;
  logic steady = 1'b0;
  int cycle_count = 0;
  int unsigned cur_len = 32'(ROW_LENGTH_RST);
  int unsigned cur_cnt = 32'(ROW_COUNT_RST);

  fdtd_field_update_stream_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_first_value   (in_cell.first_value),
    .in_second_value  (in_cell.second_value),
    .in_source_first  (in_cell.source_first),
    .in_source_second (in_cell.source_second),
    .in_first_decay   (in_cell.first_decay),
    .in_first_gain    (in_cell.first_gain),
    .in_second_decay  (in_cell.second_decay),
    .in_second_gain   (in_cell.second_gain),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_new_first    (out_new_first),
    .out_new_second   (out_new_second),
    .out_last_cell    (out_last_cell)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("%0t: timeout with %0d items outstanding", $time, sb.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 37);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_new_first, out_new_second, out_last_cell);
  end

  function automatic field_t edge_value(int k);
    case (k)
      0: return {1'b1, {(FW-1){1'b0}}};
      1: return {1'b0, {(FW-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return field_t'(1) <<< FRAC_BITS;
    endcase
  endfunction

  // mostly moderate values so that updates do not all saturate
  function automatic field_t field_sample();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return edge_value($urandom_range(0, 4));
    if (k <= 3) return field_t'($urandom());
    return field_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    c.first_value   = field_sample();
    c.second_value  = field_sample();
    c.source_first  = field_sample();
    c.source_second = field_sample();
    c.first_decay   = field_sample();
    c.first_gain    = field_sample();
    c.second_decay  = field_sample();
    c.second_gain   = field_sample();
    return c;
  endfunction

  // called just after a rising edge; leaves the write enable high
  task automatic set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // wait for the pipeline to drain before touching registers
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // send one cell, with a random gap ahead of it
  task automatic send_cell(cell_t c);
    int gaps;
    gaps = 0;
    while (!steady && $urandom_range(0, 99) < 37) gaps++;
    if (gaps != 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cell  <= c;
    do @(posedge clk); while (!in_ready);
    sb.note_cell(c);
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_cell(random_cell());
    in_valid <= 1'b0;
  endtask

  // pick bounds on one axis of extent ext and register width w
  task automatic pick_bounds(int unsigned ext, int unsigned w, output int unsigned lo,
                             output int unsigned hi);
    case ($urandom_range(0, 3))
      0, 1: begin
        lo = $urandom_range(0, ext + 1);
        hi = $urandom_range(0, ext + 1);
      end
      2: begin
        lo = 0;
        hi = (1 << w) - 1;
      end
      default: begin
        lo = $urandom_range(0, (1 << w) - 1);
        hi = $urandom_range(0, (1 << w) - 1);
      end
    endcase
  endtask

  task automatic random_config();
    int unsigned ext_len, ext_cnt, lo, hi;
    set_reg(REG_SWEEP_MODE, CFG_DATA_W'($urandom_range(0, 1)));
    if ($urandom_range(0, 9) >= 3) begin
      case ($urandom_range(0, 9))
        0:       cur_len = 0;
        1:       cur_len = $urandom_range(ROW_CAP + 1, 2047);
        2:       cur_len = ROW_CAP;
        3:       cur_len = $urandom_range(13, 64);
        default: cur_len = $urandom_range(1, 12);
      endcase
      set_reg(REG_ROW_LENGTH, CFG_DATA_W'(cur_len));
    end
    if ($urandom_range(0, 9) >= 3) begin
      case ($urandom_range(0, 9))
        0:       cur_cnt = 0;
        1:       cur_cnt = 65535;
        2, 3:    cur_cnt = $urandom_range(0, 65535);
        default: cur_cnt = $urandom_range(1, 6);
      endcase
      set_reg(REG_ROW_COUNT, CFG_DATA_W'(cur_cnt));
    end
    ext_len = (cur_len == 0) ? 1 : ((cur_len > ROW_CAP) ? ROW_CAP : cur_len);
    ext_cnt = (cur_cnt == 0) ? 1 : ((cur_cnt > 16) ? 16 : cur_cnt);
    if ($urandom_range(0, 9) >= 2) begin
      pick_bounds(ext_cnt, ROW_W, lo, hi);
      set_reg(REG_OUTER_FIRST, CFG_DATA_W'(lo));
      set_reg(REG_OUTER_STOP, CFG_DATA_W'(hi));
    end
    if ($urandom_range(0, 9) >= 2) begin
      pick_bounds(ext_len, LEN_W, lo, hi);
      set_reg(REG_INNER_FIRST, CFG_DATA_W'(lo));
      set_reg(REG_INNER_STOP, CFG_DATA_W'(hi));
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int sent;
    int phase;
    cell_t c;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: small array, whole bounds, extremes of every field, both sweeps
    cur_len = 4;
    cur_cnt = 3;
    set_reg(REG_SWEEP_MODE, CFG_DATA_W'(MODE_E));
    set_reg(REG_ROW_LENGTH, CFG_DATA_W'(cur_len));
    set_reg(REG_ROW_COUNT, CFG_DATA_W'(cur_cnt));
    set_reg(REG_OUTER_FIRST, CFG_DATA_W'(0));
    set_reg(REG_OUTER_STOP, CFG_DATA_W'(16'hffff));
    set_reg(REG_INNER_FIRST, CFG_DATA_W'(0));
    set_reg(REG_INNER_STOP, CFG_DATA_W'(11'h7ff));
    cfg_wr_en <= 1'b0;
    for (int m = 0; m < 2; m++) begin
      if (m == 1) begin
        settle();
        set_reg(REG_SWEEP_MODE, CFG_DATA_W'(MODE_H));
        cfg_wr_en <= 1'b0;
      end
      for (int k = 0; k < 12; k++) begin
        c.first_value   = edge_value((k + 0) % 5);
        c.second_value  = edge_value((k + 1) % 5);
        c.source_first  = edge_value((k + 2) % 5);
        c.source_second = edge_value((k + 3) % 5);
        c.first_decay   = edge_value((k + 4) % 5);
        c.first_gain    = edge_value((k * 2) % 5);
        c.second_decay  = edge_value((k * 3 + 1) % 5);
        c.second_gain   = edge_value((k * 4 + 2) % 5);
        send_cell(c);
      end
      in_valid <= 1'b0;
    end

    // random phases, each under a fresh setting; counters carry across
    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      int n;
      settle();
      random_config();
      steady = (phase % 10 == 7);
      n = $urandom_range(1, 40);
      send_random(n);
      sent += n;
      phase++;
    end

    // long rows in the descending sweep, no gaps on either side
    settle();
    cur_len = LONG_ROW;
    cur_cnt = 2;
    set_reg(REG_SWEEP_MODE, CFG_DATA_W'(MODE_H));
    set_reg(REG_ROW_LENGTH, CFG_DATA_W'(cur_len));
    set_reg(REG_ROW_COUNT, CFG_DATA_W'(cur_cnt));
    set_reg(REG_OUTER_FIRST, CFG_DATA_W'(0));
    set_reg(REG_OUTER_STOP, CFG_DATA_W'(2));
    set_reg(REG_INNER_FIRST, CFG_DATA_W'(3));
    set_reg(REG_INNER_STOP, CFG_DATA_W'(250));
    cfg_wr_en <= 1'b0;
    steady = 1'b1;
    send_random(2 * LONG_ROW);
    steady = 1'b0;

    settle();
    repeat (8) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fdtd_pkg.sv
rtl/fdtd_ram.sv
rtl/fdtd_ctrl.sv
rtl/fdtd_datapath.sv
rtl/fdtd_field_update_stream_top.sv
verif/fdtd_field_update_stream_top_tb.sv
